// ===== design/smac_pkg.sv =====
// shared types, constants and table functions for the attitude controller
package smac_pkg;

   localparam int unsigned NUM_REGS = 7;
   localparam logic [2:0] REG_SLOPES  = 3'd0;
   localparam logic [2:0] REG_GAINS   = 3'd1;
   localparam logic [2:0] REG_OUTGAIN = 3'd2;
   localparam logic [2:0] REG_OFFSETS = 3'd3;
   localparam logic [2:0] REG_INERTIA = 3'd4;
   localparam logic [2:0] REG_MASS    = 3'd5;
   localparam logic [2:0] REG_CENTER  = 3'd6;

   localparam logic signed [17:0] Q12_PI      = 18'sd12868;
   localparam logic signed [17:0] Q12_TWO_PI  = 18'sd25736;
   localparam logic signed [17:0] Q12_HALF_PI = 18'sd6434;
   localparam logic signed [15:0] DEG_TO_RAD  = 16'sd18292;
   localparam logic signed [16:0] GRAVITY     = 17'sd40182;
   localparam int OUT_MAX = 16383;

   // per-axis sine/tanh interpolation operands
   typedef struct packed {
      logic              neg;
      logic signed [13:0] base;
      logic signed [13:0] slope;
      logic [8:0]         frac;
   } interp_type;

   // tanh table at steps of 1/8
   function automatic logic [12:0] tanh_tab(input logic [5:0] i);
      logic [12:0] v;
      case (i)
         6'd0: v = 13'd0;     6'd1: v = 13'd509;   6'd2: v = 13'd1003;
         6'd3: v = 13'd1468;  6'd4: v = 13'd1893;  6'd5: v = 13'd2272;
         6'd6: v = 13'd2602;  6'd7: v = 13'd2883;  6'd8: v = 13'd3119;
         6'd9: v = 13'd3315;  6'd10: v = 13'd3475; 6'd11: v = 13'd3604;
         6'd12: v = 13'd3707; 6'd13: v = 13'd3790; 6'd14: v = 13'd3856;
         6'd15: v = 13'd3908; 6'd16: v = 13'd3949; 6'd17: v = 13'd3981;
         6'd18: v = 13'd4006; 6'd19: v = 13'd4026; 6'd20: v = 13'd4041;
         6'd21: v = 13'd4053; 6'd22: v = 13'd4063; 6'd23: v = 13'd4070;
         6'd24: v = 13'd4076; 6'd25: v = 13'd4080; 6'd26: v = 13'd4084;
         6'd27: v = 13'd4086; 6'd28: v = 13'd4089; 6'd29: v = 13'd4090;
         6'd30: v = 13'd4091; 6'd31: v = 13'd4092;
         default: v = 13'd4093;
      endcase
      return v;
   endfunction

   // sine table on the first quadrant at steps of 1/8
   function automatic logic [12:0] sin_tab(input logic [3:0] i);
      logic [12:0] v;
      case (i)
         4'd0: v = 13'd0;     4'd1: v = 13'd511;   4'd2: v = 13'd1013;
         4'd3: v = 13'd1500;  4'd4: v = 13'd1964;  4'd5: v = 13'd2397;
         4'd6: v = 13'd2792;  4'd7: v = 13'd3144;  4'd8: v = 13'd3447;
         4'd9: v = 13'd3696;  4'd10: v = 13'd3887; 4'd11: v = 13'd4018;
         4'd12: v = 13'd4086; default: v = 13'd4090;
      endcase
      return v;
   endfunction

   // table lookup operands for tanh of a Q12 value
   function automatic interp_type tanh_setup(input logic signed [21:0] x);
      interp_type t;
      logic [21:0] a;
      a = x[21] ? 22'(-x) : 22'(x);
      t.neg = x[21];
      if (a >= 22'd16384) begin
         t.base  = 14'sd4093;
         t.slope = 14'sd0;
         t.frac  = 9'd0;
      end else begin
         t.base  = $signed({1'b0, tanh_tab(6'(a[13:9]))});
         t.slope = $signed({1'b0, tanh_tab(6'(a[13:9]) + 6'd1)})
                 - $signed({1'b0, tanh_tab(6'(a[13:9]))});
         t.frac  = a[8:0];
      end
      return t;
   endfunction

   // table lookup operands for sine of an angle already reduced to [0, 2pi)
   function automatic interp_type sin_setup(input logic signed [17:0] r0);
      interp_type t;
      logic signed [17:0] r;
      r = r0;
      t.neg = r >= Q12_PI;
      if (t.neg) r = r - Q12_PI;
      if (r > Q12_HALF_PI) r = Q12_PI - r;
      t.base  = $signed({1'b0, sin_tab(r[12:9])});
      t.slope = $signed({1'b0, sin_tab(4'(r[12:9]) + 4'd1)})
              - $signed({1'b0, sin_tab(r[12:9])});
      t.frac  = r[8:0];
      return t;
   endfunction

   // finish the linear interpolation with rounding and apply the sign
   function automatic logic signed [13:0] interp_done(input interp_type t);
      logic signed [24:0] p;
      logic signed [13:0] y;
      p = 25'(t.slope * $signed({1'b0, t.frac})) + 25'sd256;
      y = t.base + 14'(p >>> 9);
      return t.neg ? -y : y;
   endfunction

   // reduce a 17-bit signed angle of at least -4pi into [0, 2pi)
   function automatic logic signed [17:0] wrap_2pi(input logic signed [16:0] x);
      logic signed [17:0] r;
      r = 18'(x);
      if (r < 0) r = r + Q12_TWO_PI;
      if (r < 0) r = r + Q12_TWO_PI;
      if (r >= Q12_TWO_PI) r = r - Q12_TWO_PI;
      if (r >= Q12_TWO_PI) r = r - Q12_TWO_PI;
      return r;
   endfunction

endpackage

// ===== design/smac_csr.sv =====
// configuration register file for the attitude controller
module smac_csr
   import smac_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_data,
   output logic [47:0] slopes,
   output logic [47:0] gains,
   output logic [47:0] out_gains,
   output logic [47:0] offsets,
   output logic [47:0] inertia,
   output logic [15:0] mass,
   output logic [15:0] center
);

   logic [47:0] slopes_ff, gains_ff, out_gains_ff, offsets_ff, inertia_ff;
   logic [15:0] mass_ff, center_ff;

   assign csr_ready = 1'b1;

   // register write decode
   always_ff @(posedge clock) begin
      if (reset) begin
         slopes_ff <= '0; gains_ff <= '0; out_gains_ff <= '0;
         offsets_ff <= '0; inertia_ff <= '0; mass_ff <= '0; center_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_SLOPES:  slopes_ff    <= csr_data;
            REG_GAINS:   gains_ff     <= csr_data;
            REG_OUTGAIN: out_gains_ff <= csr_data;
            REG_OFFSETS: offsets_ff   <= csr_data;
            REG_INERTIA: inertia_ff   <= csr_data;
            REG_MASS:    mass_ff      <= csr_data[15:0];
            REG_CENTER:  center_ff    <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   assign slopes = slopes_ff;
   assign gains = gains_ff;
   assign out_gains = out_gains_ff;
   assign offsets = offsets_ff;
   assign inertia = inertia_ff;
   assign mass = mass_ff;
   assign center = center_ff;

endmodule

// ===== design/sliding_mode_attitude_control_top.sv =====
// sliding mode attitude controller, pipelined top level
// a tick accepted with start passes the eight register stages of the datapath
// throughput: one tick per cycle; busy is always low, rsp_valid pulses one cycle
// and is the valid bit of the last of those stages
// synchronous active-high reset clears the valid bits and the config registers
// the receiver cannot stall, so no stage ever holds
module sliding_mode_attitude_control_top
   import smac_pkg::*;
#(
   parameter int COMMAND_LIMIT = 9600
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_ref_roll,
   input  logic signed [15:0] req_ref_pitch,
   input  logic signed [15:0] req_ref_yaw,
   input  logic signed [15:0] req_ref_rate_p,
   input  logic signed [15:0] req_ref_rate_q,
   input  logic signed [15:0] req_ref_rate_r,
   input  logic signed [15:0] req_meas_roll,
   input  logic signed [15:0] req_meas_pitch,
   input  logic signed [15:0] req_meas_yaw,
   input  logic signed [15:0] req_meas_rate_p,
   input  logic signed [15:0] req_meas_rate_q,
   input  logic signed [15:0] req_meas_rate_r,
   output logic               rsp_valid,
   output logic signed [14:0] rsp_roll_command,
   output logic signed [14:0] rsp_pitch_command,
   output logic signed [14:0] rsp_yaw_command,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [47:0]        csr_data
);

   localparam int LIM = (COMMAND_LIMIT > OUT_MAX) ? OUT_MAX : COMMAND_LIMIT;
   localparam int STAGES = 8;

   logic [47:0] slopes, gains, out_gains, offsets, inertia;
   logic [15:0] mass, center;

   smac_csr u_csr (
      .clock, .reset, .csr_valid, .csr_ready, .csr_index, .csr_data,
      .slopes, .gains, .out_gains, .offsets, .inertia, .mass, .center
   );

   assign busy = 1'b0;

   logic [STAGES-1:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= {vld_ff[STAGES-2:0], start};
   end

   // config fields
   logic signed [17:0] lam [3], mu [3], gn [3];
   logic signed [15:0] offd [3];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         lam[k]  = $signed({2'b0, slopes[16*k +: 16]});
         mu[k]   = $signed({2'b0, gains[16*k +: 16]});
         gn[k]   = $signed({2'b0, out_gains[16*k +: 16]});
         offd[k] = $signed(offsets[16*k +: 16]);
      end
   end
   logic signed [17:0] ixx, iyy, izz;
   assign ixx = $signed({2'b0, inertia[15:0]});
   assign iyy = $signed({2'b0, inertia[31:16]});
   assign izz = $signed({2'b0, inertia[47:32]});

   // mass and offset terms (config only, settled long before any tick)
   logic signed [32:0] me_ff;
   logic signed [24:0] me2_ff;
   logic signed [27:0] gm_ff;
   logic signed [48:0] me2_full, gm_full;
   logic signed [15:0] off_ff [3];
   logic signed [31:0] off_full [3];
   always_comb begin
      me2_full = 49'(me_ff * $signed(center)) + 49'sd8388608;
      gm_full  = 49'(me_ff * GRAVITY) + 49'sd2097152;
      for (int k = 0; k < 3; k++)
         off_full[k] = 32'(offd[k] * DEG_TO_RAD) + 32'sd32768;
   end
   always_ff @(posedge clock) begin
      me_ff  <= 33'($signed({1'b0, mass}) * $signed(center));
      me2_ff <= 25'(me2_full >>> 24);
      gm_ff  <= 28'(gm_full >>> 22);
      for (int k = 0; k < 3; k++) off_ff[k] <= 16'(off_full[k] >>> 16);
   end

   // stage 1: errors, yaw wrap, angle prep, rate products
   logic signed [17:0] s1_ea_ff [3], s1_ew_ff [3];
   logic signed [15:0] s1_w_ff [3];
   logic signed [17:0] s1_sm_ff [2], s1_sr_ff [2];
   logic signed [31:0] s1_rq_ff, s1_rp_ff, s1_pq_ff;
   always_ff @(posedge clock) begin
      logic signed [17:0] ey;
      s1_ea_ff[0] <= 18'(req_ref_roll) - 18'(req_meas_roll) - 18'(off_ff[0]);
      s1_ea_ff[1] <= 18'(req_ref_pitch) - 18'(req_meas_pitch) - 18'(off_ff[1]);
      ey = 18'(req_ref_yaw) - 18'(req_meas_yaw);
      if (ey > Q12_PI) ey = ey - Q12_TWO_PI;
      if (ey > Q12_PI) ey = ey - Q12_TWO_PI;
      if (ey > Q12_PI) ey = ey - Q12_TWO_PI;
      if (ey < -Q12_PI) ey = ey + Q12_TWO_PI;
      if (ey < -Q12_PI) ey = ey + Q12_TWO_PI;
      if (ey < -Q12_PI) ey = ey + Q12_TWO_PI;
      s1_ea_ff[2] <= ey - 18'(off_ff[2]);
      s1_ew_ff[0] <= 18'(req_ref_rate_p) - 18'(req_meas_rate_p);
      s1_ew_ff[1] <= 18'(req_ref_rate_q) - 18'(req_meas_rate_q);
      s1_ew_ff[2] <= 18'(req_ref_rate_r) - 18'(req_meas_rate_r);
      s1_w_ff[0] <= req_meas_rate_p;
      s1_w_ff[1] <= req_meas_rate_q;
      s1_w_ff[2] <= req_meas_rate_r;
      s1_sm_ff[0] <= wrap_2pi(17'(req_meas_roll));
      s1_sm_ff[1] <= wrap_2pi(17'(req_meas_pitch));
      s1_sr_ff[0] <= wrap_2pi(17'(req_ref_roll) + 17'(off_ff[0]));
      s1_sr_ff[1] <= wrap_2pi(17'(req_ref_pitch) + 17'(off_ff[1]));
      s1_rq_ff <= req_meas_rate_r * req_meas_rate_q;
      s1_rp_ff <= req_meas_rate_r * req_meas_rate_p;
      s1_pq_ff <= req_meas_rate_p * req_meas_rate_q;
   end

   // stage 2: sliding surfaces, sine lookup, rate products rounded or scaled by inertia
   logic signed [21:0] s2_sig_ff [3];
   logic signed [17:0] s2_ew_ff [3];
   logic signed [15:0] s2_r_ff;
   interp_type s2_sm_ff [2], s2_sr_ff [2];
   logic signed [19:0] s2_rq_ff, s2_rp_ff;
   logic signed [49:0] s2_pqi_ff;
   always_ff @(posedge clock) begin
      logic signed [36:0] t;
      for (int k = 0; k < 3; k++) begin
         t = 37'(lam[k] * s1_ea_ff[k]) + 37'sd2048;
         s2_sig_ff[k] <= 22'(s1_ew_ff[k]) + 22'(t >>> 12);
         s2_ew_ff[k] <= s1_ew_ff[k];
      end
      s2_r_ff <= s1_w_ff[2];
      for (int k = 0; k < 2; k++) begin
         s2_sm_ff[k] <= sin_setup(s1_sm_ff[k]);
         s2_sr_ff[k] <= sin_setup(s1_sr_ff[k]);
      end
      s2_rq_ff <= 20'((s1_rq_ff + 32'sd2048) >>> 12);
      s2_rp_ff <= 20'((s1_rp_ff + 32'sd2048) >>> 12);
      s2_pqi_ff <= 50'((iyy - ixx) * s1_pq_ff);
   end

   // stage 3: tanh setup, sine done, inertia rate product rounded
   interp_type s3_th_ff [3];
   logic signed [17:0] s3_ew_ff [3];
   logic signed [15:0] s3_r_ff;
   logic signed [14:0] s3_sd_ff [2];
   logic signed [19:0] s3_rq_ff, s3_rp_ff;
   logic signed [34:0] s3_pq_ff;
   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         s3_th_ff[k] <= tanh_setup(s2_sig_ff[k]);
         s3_ew_ff[k] <= s2_ew_ff[k];
      end
      for (int k = 0; k < 2; k++)
         s3_sd_ff[k] <= 15'(interp_done(s2_sm_ff[k])) - 15'(interp_done(s2_sr_ff[k]));
      s3_r_ff <= s2_r_ff;
      s3_rq_ff <= s2_rq_ff;
      s3_rp_ff <= s2_rp_ff;
      s3_pq_ff <= 35'((s2_pqi_ff + 50'sd32768) >>> 16);
   end

   // stage 4: tanh done, rate-slope products, gyro and gravity products
   logic signed [13:0] s4_th_ff [3];
   logic signed [35:0] s4_lw_ff [3];
   logic signed [44:0] s4_gy_ff [2];
   logic signed [42:0] s4_gr_ff [2];
   logic signed [34:0] s4_pq_ff;
   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         s4_th_ff[k] <= interp_done(s3_th_ff[k]);
         s4_lw_ff[k] <= (k == 2) ? 36'(lam[k] * s3_r_ff) : 36'(lam[k] * s3_ew_ff[k]);
      end
      s4_gy_ff[0] <= 45'((25'(izz) - 25'(iyy) - me2_ff) * s3_rq_ff);
      s4_gy_ff[1] <= 45'((25'(ixx) - 25'(izz) + me2_ff) * s3_rp_ff);
      for (int k = 0; k < 2; k++) s4_gr_ff[k] <= 43'(s3_sd_ff[k] * gm_ff);
      s4_pq_ff <= s3_pq_ff;
   end

   // stage 5: switching term plus slope term, plus the inertia rate term on yaw, rounded on roll and pitch
   logic signed [37:0] s5_in_ff [3];
   logic signed [44:0] s5_gy_ff [2];
   logic signed [42:0] s5_gr_ff [2];
   always_ff @(posedge clock) begin
      logic signed [37:0] v;
      for (int k = 0; k < 3; k++) begin
         v = 38'(s4_th_ff[k] * mu[k]) + 38'(s4_lw_ff[k]);
         if (k == 2) s5_in_ff[k] <= v + 38'(s4_pq_ff);
         else s5_in_ff[k] <= 38'((v + 38'sd2048) >>> 12);
      end
      for (int k = 0; k < 2; k++) begin
         s5_gy_ff[k] <= s4_gy_ff[k];
         s5_gr_ff[k] <= s4_gr_ff[k];
      end
   end

   // stage 6: inertia product for each axis
   logic signed [56:0] s6_ia_ff [3];
   logic signed [44:0] s6_gy_ff [2];
   logic signed [42:0] s6_gr_ff [2];
   always_ff @(posedge clock) begin
      s6_ia_ff[0] <= 57'((25'(ixx) + me2_ff) * s5_in_ff[0]);
      s6_ia_ff[1] <= 57'((25'(iyy) + me2_ff) * s5_in_ff[1]);
      s6_ia_ff[2] <= 57'(izz * s5_in_ff[2]);
      s6_gy_ff <= s5_gy_ff;
      s6_gr_ff <= s5_gr_ff;
   end

   // stage 7: sum and rounding
   logic signed [44:0] s7_s_ff [3];
   always_ff @(posedge clock) begin
      logic signed [57:0] s;
      for (int k = 0; k < 2; k++) begin
         s = -58'(s6_ia_ff[k]) + 58'(s6_gy_ff[k]) + 58'(s6_gr_ff[k]) + 58'sd2048;
         s7_s_ff[k] <= 45'(s >>> 12);
      end
      s = 58'(s6_ia_ff[2]) + 58'sd8388608;
      s7_s_ff[2] <= 45'(s >>> 24);
   end

   // stage 8: output gain, rounding, negation on roll and pitch, and clamp
   logic signed [14:0] cmd_ff [3];
   always_ff @(posedge clock) begin
      logic signed [63:0] p, c;
      for (int k = 0; k < 3; k++) begin
         p = (64'(s7_s_ff[k] * gn[k]) + 64'sd8388608) >>> 24;
         c = (k == 2) ? p : -p;
         if (c > 64'(LIM)) c = 64'(LIM);
         if (c < -64'(LIM)) c = -64'(LIM);
         cmd_ff[k] <= 15'(c);
      end
   end

   assign rsp_valid = vld_ff[STAGES-1];
   assign rsp_roll_command = cmd_ff[0];
   assign rsp_pitch_command = cmd_ff[1];
   assign rsp_yaw_command = cmd_ff[2];

endmodule

// ===== design/smac_checker.sv =====
// port-level checks for the attitude controller
module smac_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic signed [14:0] rsp_roll_command,
   input logic signed [14:0] rsp_yaw_command
);
   // every result follows a start at the depth of the pipeline
   a_lat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 8))
      else $error("result without start");
   // nothing lost
   a_keep: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##8 (rsp_valid || reset))
      else $error("result lost");
   a_busy: assert property (@(posedge clock) !busy)
      else $error("busy raised");
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_roll_command <= 15'sd16383) && (rsp_roll_command >= -15'sd16383)
                 && (rsp_yaw_command >= -15'sd16383))
      else $error("command out of range");
endmodule

bind sliding_mode_attitude_control_top smac_checker u_chk (
   .clock, .reset, .start, .busy, .rsp_valid, .rsp_roll_command, .rsp_yaw_command
);

// ===== tb/sv/sliding_mode_attitude_control_top_tb.sv =====
// self-checking testbench for the sliding mode attitude controller top level
`timescale 1ns / 1ps

module sliding_mode_attitude_control_top_tb;
   import smac_pkg::*;

   localparam int CMD_LIMIT = 9600;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT = 400000;

   localparam longint TANH_LUT [33] = '{
      0, 509, 1003, 1468, 1893, 2272, 2602, 2883, 3119, 3315, 3475,
      3604, 3707, 3790, 3856, 3908, 3949, 3981, 4006, 4026, 4041, 4053,
      4063, 4070, 4076, 4080, 4084, 4086, 4089, 4090, 4091, 4092, 4093};
   localparam longint SIN_LUT [14] = '{
      0, 511, 1013, 1500, 1964, 2397, 2792, 3144, 3447, 3696, 3887,
      4018, 4086, 4090};

   // tick layout: ref angles 0..2, ref rates 3..5, meas angles 6..8, meas rates 9..11
   typedef logic [11:0][15:0] tick_type;
   typedef struct packed {
      logic signed [14:0] roll;
      logic signed [14:0] pitch;
      logic signed [14:0] yaw;
   } cmd_type;
   typedef struct packed {
      logic [2:0]  index;
      logic [47:0] data;
   } csr_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [15:0] req_ref_roll = '0, req_ref_pitch = '0, req_ref_yaw = '0;
   logic signed [15:0] req_ref_rate_p = '0, req_ref_rate_q = '0, req_ref_rate_r = '0;
   logic signed [15:0] req_meas_roll = '0, req_meas_pitch = '0, req_meas_yaw = '0;
   logic signed [15:0] req_meas_rate_p = '0, req_meas_rate_q = '0, req_meas_rate_r = '0;
   logic rsp_valid;
   logic signed [14:0] rsp_roll_command, rsp_pitch_command, rsp_yaw_command;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [47:0] csr_data = '0;

   tick_type tick_q [$];
   cmd_type cmd_expected_q [$];
   csr_beat_type csr_q [$];
   logic [47:0] shadow_regs [NUM_REGS];
   int mismatches = 0;
   int accepted = 0;
   int cycles = 0;

   sliding_mode_attitude_control_top #(.COMMAND_LIMIT(CMD_LIMIT)) uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_ref_roll(req_ref_roll), .req_ref_pitch(req_ref_pitch),
      .req_ref_yaw(req_ref_yaw), .req_ref_rate_p(req_ref_rate_p),
      .req_ref_rate_q(req_ref_rate_q), .req_ref_rate_r(req_ref_rate_r),
      .req_meas_roll(req_meas_roll), .req_meas_pitch(req_meas_pitch),
      .req_meas_yaw(req_meas_yaw), .req_meas_rate_p(req_meas_rate_p),
      .req_meas_rate_q(req_meas_rate_q), .req_meas_rate_r(req_meas_rate_r),
      .rsp_valid(rsp_valid), .rsp_roll_command(rsp_roll_command),
      .rsp_pitch_command(rsp_pitch_command), .rsp_yaw_command(rsp_yaw_command),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   // round to nearest, ties up, dropping n bits
   function automatic longint round_shift(input longint v, input int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
   endfunction

   function automatic longint tanh_fx(input longint x);
      longint a, y, i;
      a = (x < 0) ? -x : x;
      if (a >= 16384) y = TANH_LUT[32];
      else begin
         i = a >>> 9;
         y = TANH_LUT[i] + round_shift((TANH_LUT[i + 1] - TANH_LUT[i]) * (a & 511), 9);
      end
      return (x < 0) ? -y : y;
   endfunction

   function automatic longint sin_fx(input longint x);
      longint r, i, y;
      logic neg;
      r = x % longint'(Q12_TWO_PI);
      if (r < 0) r = r + Q12_TWO_PI;
      neg = r >= Q12_PI;
      if (neg) r = r - Q12_PI;
      if (r > Q12_HALF_PI) r = Q12_PI - r;
      i = r >>> 9;
      y = SIN_LUT[i] + round_shift((SIN_LUT[i + 1] - SIN_LUT[i]) * (r & 511), 9);
      return neg ? -y : y;
   endfunction

   function automatic logic signed [14:0] clamp_cmd(input longint v);
      longint lim;
      lim = (CMD_LIMIT > OUT_MAX) ? OUT_MAX : CMD_LIMIT;
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      return 15'(v);
   endfunction

   function automatic longint slot(input int r, input int k);
      return longint'(shadow_regs[r][16 * k +: 16]);
   endfunction

   // expected commands for one control tick under the current shadow registers
   function automatic cmd_type predict_commands(input tick_type t);
      longint ref_a [3], meas_a [3], err_a [3], err_w [3], meas_w [3];
      longint lam [3], mu [3], gain [3], off [3], sig [3];
      longint ixx, iyy, izz, m, e, me, me2, gm, a, s, inner;
      cmd_type c;
      for (int k = 0; k < 3; k++) begin
         ref_a[k] = longint'($signed(t[k]));
         meas_a[k] = longint'($signed(t[6 + k]));
         meas_w[k] = longint'($signed(t[9 + k]));
         err_a[k] = ref_a[k] - meas_a[k];
         err_w[k] = longint'($signed(t[3 + k])) - meas_w[k];
         lam[k] = slot(REG_SLOPES, k);
         mu[k] = slot(REG_GAINS, k);
         gain[k] = slot(REG_OUTGAIN, k);
         off[k] = round_shift(longint'($signed(shadow_regs[REG_OFFSETS][16 * k +: 16]))
                              * DEG_TO_RAD, 16);
      end
      // yaw error wrap into +-pi
      while (err_a[2] > Q12_PI) err_a[2] = err_a[2] - Q12_TWO_PI;
      while (err_a[2] < -Q12_PI) err_a[2] = err_a[2] + Q12_TWO_PI;
      for (int k = 0; k < 3; k++)
         sig[k] = err_w[k] + round_shift(lam[k] * (err_a[k] - off[k]), 12);
      ixx = slot(REG_INERTIA, 0);
      iyy = slot(REG_INERTIA, 1);
      izz = slot(REG_INERTIA, 2);
      m = longint'(shadow_regs[REG_MASS][15:0]);
      e = longint'($signed(shadow_regs[REG_CENTER][15:0]));
      me = m * e;
      me2 = round_shift(me * e, 24);
      gm = round_shift(me * GRAVITY, 22);
      // roll
      a = round_shift(tanh_fx(sig[0]) * mu[0] + lam[0] * err_w[0], 12);
      s = -(ixx + me2) * a + (izz - iyy - me2) * round_shift(meas_w[2] * meas_w[1], 12)
          + (sin_fx(meas_a[0]) - sin_fx(ref_a[0] + off[0])) * gm;
      c.roll = clamp_cmd(-round_shift(round_shift(s, 12) * gain[0], 24));
      // pitch
      a = round_shift(tanh_fx(sig[1]) * mu[1] + lam[1] * err_w[1], 12);
      s = -(iyy + me2) * a + (ixx - izz + me2) * round_shift(meas_w[2] * meas_w[0], 12)
          + (sin_fx(meas_a[1]) - sin_fx(ref_a[1] + off[1])) * gm;
      c.pitch = clamp_cmd(-round_shift(round_shift(s, 12) * gain[1], 24));
      // yaw
      inner = tanh_fx(sig[2]) * mu[2] + lam[2] * meas_w[2]
              + round_shift((iyy - ixx) * (meas_w[0] * meas_w[1]), 16);
      c.yaw = clamp_cmd(round_shift(round_shift(izz * inner, 24) * gain[2], 24));
      return c;
   endfunction

   // tick driver: predicts on every accepted beat, then presents the next one
   always @(posedge clock) begin
      logic calm;
      tick_type t;
      cycles <= cycles + 1;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            cmd_expected_q.push_back(predict_commands({req_meas_rate_r, req_meas_rate_q,
               req_meas_rate_p, req_meas_yaw, req_meas_pitch, req_meas_roll,
               req_ref_rate_r, req_ref_rate_q, req_ref_rate_p, req_ref_yaw,
               req_ref_pitch, req_ref_roll}));
            accepted <= accepted + 1;
         end
         if (!(start && busy)) begin
            calm = accepted >= 150 && accepted < 260;
            if (tick_q.size() == 0 || (!calm && $urandom_range(99) < 35)) begin
               start <= 1'b0;
            end else begin
               t = tick_q.pop_front();
               start <= 1'b1;
               req_ref_roll <= t[0];    req_ref_pitch <= t[1];    req_ref_yaw <= t[2];
               req_ref_rate_p <= t[3];  req_ref_rate_q <= t[4];   req_ref_rate_r <= t[5];
               req_meas_roll <= t[6];   req_meas_pitch <= t[7];   req_meas_yaw <= t[8];
               req_meas_rate_p <= t[9]; req_meas_rate_q <= t[10]; req_meas_rate_r <= t[11];
            end
         end
      end
   end

   // register write driver, keeps the shadow copy in step
   always @(posedge clock) begin
      csr_beat_type b;
      if (reset) begin
         csr_valid <= 1'b0;
         for (int i = 0; i < NUM_REGS; i++) shadow_regs[i] = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index < REG_MASS) shadow_regs[csr_index] = csr_data;
            else if (csr_index < NUM_REGS) shadow_regs[csr_index] = {32'd0, csr_data[15:0]};
         end
         if (!(csr_valid && !csr_ready)) begin
            if (csr_q.size() == 0 || $urandom_range(99) < 35) begin
               csr_valid <= 1'b0;
            end else begin
               b = csr_q.pop_front();
               csr_valid <= 1'b1;
               csr_index <= b.index;
               csr_data <= b.data;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      cmd_type want;
      if (!reset && rsp_valid) begin
         if (cmd_expected_q.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("unexpected result beat");
         end else begin
            want = cmd_expected_q.pop_front();
            if (rsp_roll_command !== want.roll || rsp_pitch_command !== want.pitch ||
                rsp_yaw_command !== want.yaw) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("mismatch: expected roll %0d pitch %0d yaw %0d, got %0d %0d %0d",
                           want.roll, want.pitch, want.yaw, rsp_roll_command,
                           rsp_pitch_command, rsp_yaw_command);
            end
         end
      end
   end

   // run watchdog
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic [15:0] rand_slot();
      case ($urandom_range(3))
         0: return 16'($urandom);
         1: return 16'($urandom_range(4096));
         2: return 16'h0000;
         default: return 16'hffff;
      endcase
   endfunction

   function automatic tick_type rand_tick();
      tick_type t;
      int mode;
      mode = $urandom_range(2);
      for (int i = 0; i < 12; i++) begin
         if (mode == 0) t[i] = 16'($urandom);
         else t[i] = 16'($urandom_range(6000) - 3000);
      end
      // tracking case: measurement close to reference
      if (mode == 2)
         for (int i = 6; i < 12; i++) t[i] = t[i - 6] + 16'($urandom_range(400) - 200);
      return t;
   endfunction

   task automatic write_all(input logic [47:0] v [NUM_REGS]);
      for (int i = 0; i < NUM_REGS; i++) csr_q.push_back({3'(i), v[i]});
   endtask

   task automatic drain();
      while (tick_q.size() > 0 || start || cmd_expected_q.size() > 0 || csr_q.size() > 0 ||
             csr_valid)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [47:0] regs [NUM_REGS];
      tick_type t;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: moderate gains, extremes and wrap cases
      regs = '{{16'd4096, 16'd2048, 16'd8192}, {16'd4096, 16'd8192, 16'd2048},
               {16'd256, 16'd512, 16'd128}, {16'hfb00, 16'd1280, 16'h0a00},
               {16'd3000, 16'd2000, 16'd1000}, 48'd8192, 48'hffff_ffff_c000};
      write_all(regs);
      csr_q.push_back({3'd7, 48'hffff_ffff_ffff});
      drain();
      tick_q.push_back('0);
      tick_q.push_back({12{16'h7fff}});
      tick_q.push_back({12{16'h8000}});
      tick_q.push_back({{6{16'h8000}}, {6{16'h7fff}}});
      tick_q.push_back({{6{16'h7fff}}, {6{16'h8000}}});
      t = '0; t[2] = 16'h7fff; t[8] = 16'h8000; tick_q.push_back(t);
      t = '0; t[2] = 16'h8000; t[8] = 16'h7fff; tick_q.push_back(t);
      t = '0; t[2] = 16'd12869; tick_q.push_back(t);
      t = '0; t[2] = -16'sd12869; tick_q.push_back(t);
      t = '0; t[3] = 16'd20000; t[4] = -16'sd20000; t[5] = 16'd16384; tick_q.push_back(t);
      t = '0; t[0] = 16'd30000; t[6] = -16'sd30000; t[1] = 16'd25736; tick_q.push_back(t);
      t = '0; t[9] = 16'h7fff; t[10] = 16'h7fff; t[11] = 16'h8000; tick_q.push_back(t);
      t = '0; t[0] = 16'd6434; t[7] = 16'd6434; t[1] = 16'd12868; tick_q.push_back(t);
      for (int i = 0; i < 12; i++) begin
         t = '0; t[i] = 16'h5555 << (i % 2); tick_q.push_back(t);
      end
      drain();

      // full-scale and all-zero register settings
      for (int i = 0; i < NUM_REGS; i++) regs[i] = '1;
      write_all(regs);
      drain();
      repeat (40) tick_q.push_back(rand_tick());
      drain();
      for (int i = 0; i < NUM_REGS; i++) regs[i] = '0;
      write_all(regs);
      drain();
      repeat (20) tick_q.push_back(rand_tick());
      drain();

      // random register settings, each followed by random ticks
      for (int p = 0; p < 7; p++) begin
         for (int i = 0; i < NUM_REGS; i++)
            regs[i] = {rand_slot(), rand_slot(), rand_slot()};
         write_all(regs);
         drain();
         repeat (50) tick_q.push_back(rand_tick());
         drain();
      end

      if (mismatches == 0 && cmd_expected_q.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== files.f =====
design/smac_pkg.sv
design/smac_csr.sv
design/sliding_mode_attitude_control_top.sv
design/smac_checker.sv
tb/sv/sliding_mode_attitude_control_top_tb.sv
